@@ rtl/lsdr_pkg.sv @@
// Package for the decimal LSD radix sort core: sizes, item types and
// the reciprocal constants of the digit unit. No dependencies.
package lsdr_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int RADIX       = 10;

    localparam int CNT_W  = 20;
    localparam int TAG_W  = 16;
    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int FILL_W = $clog2(MAX_ENTRIES + 1);
    localparam int DIG_W  = $clog2(RADIX);

    // Quotient by RADIX as a multiply by a rounded-up reciprocal.
    localparam int RECIP_SH = CNT_W + 5;
    localparam longint RECIP = ((64'd1 << RECIP_SH) + RADIX - 1) / RADIX;
    localparam int RECIP_W  = $clog2(RECIP + 1);
    localparam int PROD_W   = CNT_W + RECIP_W;

    // Record as held in the stores: count, tag and the count divided by
    // the weight of the current pass.
    localparam int REC_W = CNT_W + TAG_W + CNT_W;

    typedef struct packed {
        logic [CNT_W-1:0] occ_count;
        logic [TAG_W-1:0] key_tag;
        logic             is_last;
    } in_item_t;

    typedef struct packed {
        logic [CNT_W-1:0] sorted_count;
        logic [TAG_W-1:0] sorted_tag;
        logic             last_out;
    } out_item_t;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [TAG_W-1:0] tag;
        logic [CNT_W-1:0] res;
    } rec_t;

    typedef struct packed {
        logic [CNT_W-1:0] quot;
        logic [DIG_W-1:0] digit;
    } digit_res_t;

endpackage

@@ rtl/lsdr_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module lsdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/lsdr_digit_unit.sv @@
// Shared divide-by-radix unit: registered reciprocal multiply, then the
// remainder as the low digit. Depends on lsdr_pkg.
module lsdr_digit_unit (
    input  logic                      aclk,
    input  logic [lsdr_pkg::CNT_W-1:0] in_val,
    output lsdr_pkg::digit_res_t       result
);
    import lsdr_pkg::*;

    logic [CNT_W-1:0]  val_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] shifted;
    logic [CNT_W-1:0]  quot;
    logic [CNT_W-1:0]  back;

    always_ff @(posedge aclk) begin
        val_reg  <= in_val;
        prod_reg <= PROD_W'(in_val) * PROD_W'(RECIP);
    end

    always_comb begin
        shifted      = prod_reg >> RECIP_SH;
        quot         = shifted[CNT_W-1:0];
        back         = CNT_W'(quot * CNT_W'(RADIX));
        result.quot  = quot;
        result.digit = DIG_W'(val_reg - back);
    end
endmodule

@@ rtl/lsd_decimal_radix_sort_core.sv @@
// Decimal LSD radix sort core. Depends on lsdr_pkg, lsdr_ram, lsdr_digit_unit.
// Load: one item per cycle while idle. After the last item the core is busy:
// per pass a histogram walk, a prefix sum over the RADIX bins and a scatter walk,
// one pass per decimal digit of the largest count, set by the shared divide unit.
// Emit: each result item is read, captured and shown until taken. Reset (aresetn, sync,
// active low) clears control and bins; the record stores are not cleared.
module lsd_decimal_radix_sort_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lsdr_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lsdr_pkg::out_item_t  m_data
);
    import lsdr_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CHK   = 4'd1;
    localparam logic [3:0] ST_H_RD  = 4'd2;
    localparam logic [3:0] ST_H_MUL = 4'd3;
    localparam logic [3:0] ST_H_ACT = 4'd4;
    localparam logic [3:0] ST_PFX   = 4'd5;
    localparam logic [3:0] ST_S_RD  = 4'd6;
    localparam logic [3:0] ST_S_MUL = 4'd7;
    localparam logic [3:0] ST_S_ACT = 4'd8;
    localparam logic [3:0] ST_M_DIV = 4'd9;
    localparam logic [3:0] ST_M_UPD = 4'd10;
    localparam logic [3:0] ST_O_RD  = 4'd11;
    localparam logic [3:0] ST_O_CAP = 4'd12;
    localparam logic [3:0] ST_O_SHW = 4'd13;

    logic [3:0]        state_reg, state_next;
    logic [FILL_W-1:0] loaded_reg, loaded_next;
    logic [FILL_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [DIG_W-1:0]  k_reg, k_next;
    logic [FILL_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]  maxres_reg, maxres_next;
    logic              sel_reg, sel_next;
    logic [FILL_W-1:0] bins_reg [RADIX];
    logic [FILL_W-1:0] bins_next [RADIX];
    out_item_t         out_reg, out_next;
    logic              mvalid_reg, mvalid_next;

    logic [IDX_W-1:0]  n_last;
    logic [REC_W-1:0]  rd0, rd1;
    rec_t              rd_rec;
    logic              we0, we1;
    logic [IDX_W-1:0]  waddr;
    rec_t              wrec;
    logic [CNT_W-1:0]  div_in;
    digit_res_t        dres;
    logic [DIG_W-1:0]  bin_idx;
    logic [FILL_W-1:0] bin_val;
    logic [FILL_W-1:0] pfx_sum;
    logic              load_wr, scat_wr;

    assign n_last  = IDX_W'(n_reg - FILL_W'(1));
    assign rd_rec  = sel_reg ? rec_t'(rd1) : rec_t'(rd0);
    assign div_in  = (state_reg == ST_M_DIV) ? maxres_reg : rd_rec.res;
    assign bin_idx = (state_reg == ST_PFX) ? k_reg : dres.digit;
    assign bin_val = bins_reg[bin_idx];
    assign pfx_sum = acc_reg + bin_val;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mvalid_reg;
    assign m_data  = out_reg;

    // Load writes the current bank; scatter writes the other one.
    assign load_wr = s_valid && s_ready && (loaded_reg < FILL_W'(MAX_ENTRIES));
    assign scat_wr = (state_reg == ST_S_ACT);
    assign we0     = (load_wr && !sel_reg) || (scat_wr && sel_reg);
    assign we1     = (load_wr && sel_reg) || (scat_wr && !sel_reg);

    always_comb begin
        if (scat_wr) begin
            waddr    = IDX_W'(bin_val - FILL_W'(1));
            wrec.cnt = rd_rec.cnt;
            wrec.tag = rd_rec.tag;
            wrec.res = dres.quot;
        end else begin
            waddr    = loaded_reg[IDX_W-1:0];
            wrec.cnt = s_data.occ_count;
            wrec.tag = s_data.key_tag;
            wrec.res = s_data.occ_count;
        end
    end

    lsdr_ram #(.WIDTH(REC_W), .DEPTH(MAX_ENTRIES)) u_bank0 (
        .aclk(aclk), .we(we0), .waddr(waddr), .wdata(wrec),
        .raddr(idx_reg), .rdata(rd0)
    );

    lsdr_ram #(.WIDTH(REC_W), .DEPTH(MAX_ENTRIES)) u_bank1 (
        .aclk(aclk), .we(we1), .waddr(waddr), .wdata(wrec),
        .raddr(idx_reg), .rdata(rd1)
    );

    lsdr_digit_unit u_digit (
        .aclk(aclk), .in_val(div_in), .result(dres)
    );

    always_comb begin
        state_next  = state_reg;
        loaded_next = loaded_reg;
        n_next      = n_reg;
        idx_next    = idx_reg;
        k_next      = k_reg;
        acc_next    = acc_reg;
        maxres_next = maxres_reg;
        sel_next    = sel_reg;
        bins_next   = bins_reg;
        out_next    = out_reg;
        mvalid_next = mvalid_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    // Track the largest count while loading; drop items once full.
                    if (load_wr) begin
                        loaded_next = loaded_reg + FILL_W'(1);
                        if (loaded_reg == '0 || s_data.occ_count > maxres_reg) begin
                            maxres_next = s_data.occ_count;
                        end
                    end
                    if (s_data.is_last) begin
                        n_next      = load_wr ? loaded_reg + FILL_W'(1) : loaded_reg;
                        loaded_next = '0;
                        state_next  = ST_CHK;
                    end
                end
            end
            ST_CHK: begin
                // Run another pass while digits of the largest count remain.
                if (maxres_reg == '0) begin
                    idx_next   = n_last;
                    state_next = ST_O_RD;
                end else begin
                    for (int b = 0; b < RADIX; b++) begin
                        bins_next[b] = '0;
                    end
                    acc_next   = '0;
                    idx_next   = '0;
                    state_next = ST_H_RD;
                end
            end
            ST_H_RD:  state_next = ST_H_MUL;
            ST_H_MUL: state_next = ST_H_ACT;
            ST_H_ACT: begin
                bins_next[bin_idx] = bin_val + FILL_W'(1);
                if (idx_reg == n_last) begin
                    k_next     = '0;
                    state_next = ST_PFX;
                end else begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_H_RD;
                end
            end
            ST_PFX: begin
                bins_next[bin_idx] = pfx_sum;
                acc_next           = pfx_sum;
                if (k_reg == DIG_W'(RADIX - 1)) begin
                    idx_next   = n_last;
                    state_next = ST_S_RD;
                end else begin
                    k_next = k_reg + DIG_W'(1);
                end
            end
            ST_S_RD:  state_next = ST_S_MUL;
            ST_S_MUL: state_next = ST_S_ACT;
            ST_S_ACT: begin
                // Walk downwards so equal digits keep their order.
                bins_next[bin_idx] = bin_val - FILL_W'(1);
                if (idx_reg == '0) begin
                    state_next = ST_M_DIV;
                end else begin
                    idx_next   = idx_reg - IDX_W'(1);
                    state_next = ST_S_RD;
                end
            end
            ST_M_DIV: state_next = ST_M_UPD;
            ST_M_UPD: begin
                maxres_next = dres.quot;
                sel_next    = !sel_reg;
                state_next  = ST_CHK;
            end
            ST_O_RD:  state_next = ST_O_CAP;
            ST_O_CAP: begin
                out_next.sorted_count = rd_rec.cnt;
                out_next.sorted_tag   = rd_rec.tag;
                out_next.last_out     = (idx_reg == '0);
                mvalid_next           = 1'b1;
                state_next            = ST_O_SHW;
            end
            ST_O_SHW: begin
                if (m_ready) begin
                    mvalid_next = 1'b0;
                    if (idx_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg - IDX_W'(1);
                        state_next = ST_O_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            loaded_reg <= '0;
            n_reg      <= '0;
            idx_reg    <= '0;
            k_reg      <= '0;
            acc_reg    <= '0;
            maxres_reg <= '0;
            sel_reg    <= 1'b0;
            mvalid_reg <= 1'b0;
            for (int b = 0; b < RADIX; b++) begin
                bins_reg[b] <= '0;
            end
        end else begin
            state_reg  <= state_next;
            loaded_reg <= loaded_next;
            n_reg      <= n_next;
            idx_reg    <= idx_next;
            k_reg      <= k_next;
            acc_reg    <= acc_next;
            maxres_reg <= maxres_next;
            sel_reg    <= sel_next;
            mvalid_reg <= mvalid_next;
            bins_reg   <= bins_next;
        end
        out_reg <= out_next;
    end
endmodule

@@ rtl/lsdr_checker.sv @@
// Port-level checks for the radix sort core, bound to the top level.
// Depends on lsdr_pkg and lsd_decimal_radix_sort_core.
module lsdr_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input lsdr_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input lsdr_pkg::out_item_t m_data
);
    import lsdr_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result item changed");

    a_no_load_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready while a result is shown");

    a_quiet_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_data.is_last |=> !m_valid && s_ready)
        else $error("non-final item gave a result");

    a_ready_after_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.last_out |=> s_ready && !m_valid)
        else $error("core not ready after the final result");
endmodule

bind lsd_decimal_radix_sort_core lsdr_checker u_lsdr_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
